>>> rtl/core/sltu_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sltu_pkg
// shared constants, token kind codes and character helpers for the tokenizer
// -----------------------------------------------------------------------------
package sltu_pkg;

   localparam int OFFSET_BITS_DEF     = 24;
   localparam int LINE_BITS_DEF       = 20;
   localparam int KEYWORD_MAX_LEN_DEF = 6;

   localparam int KIND_BITS = 6;
   localparam int ERR_BITS  = 2;

   typedef logic [KIND_BITS-1:0] kind_type;
   typedef logic [ERR_BITS-1:0]  err_type;

   localparam kind_type TK_LPAREN  = 6'd0;
   localparam kind_type TK_RPAREN  = 6'd1;
   localparam kind_type TK_LBRACE  = 6'd2;
   localparam kind_type TK_RBRACE  = 6'd3;
   localparam kind_type TK_COMMA   = 6'd4;
   localparam kind_type TK_DOT     = 6'd5;
   localparam kind_type TK_MINUS   = 6'd6;
   localparam kind_type TK_PLUS    = 6'd7;
   localparam kind_type TK_SEMI    = 6'd8;
   localparam kind_type TK_SLASH   = 6'd9;
   localparam kind_type TK_STAR    = 6'd10;
   localparam kind_type TK_BANG    = 6'd11;
   localparam kind_type TK_EQUAL   = 6'd13;
   localparam kind_type TK_GREATER = 6'd15;
   localparam kind_type TK_LESS    = 6'd17;
   localparam kind_type TK_IDENT   = 6'd19;
   localparam kind_type TK_STRING  = 6'd20;
   localparam kind_type TK_NUMBER  = 6'd21;
   localparam kind_type TK_AND     = 6'd22;
   localparam kind_type TK_CLASS   = 6'd23;
   localparam kind_type TK_ELSE    = 6'd24;
   localparam kind_type TK_FALSE   = 6'd25;
   localparam kind_type TK_FOR     = 6'd26;
   localparam kind_type TK_FUN     = 6'd27;
   localparam kind_type TK_IF      = 6'd28;
   localparam kind_type TK_NIL     = 6'd29;
   localparam kind_type TK_OR      = 6'd30;
   localparam kind_type TK_PRINT   = 6'd31;
   localparam kind_type TK_RETURN  = 6'd32;
   localparam kind_type TK_SUPER   = 6'd33;
   localparam kind_type TK_THIS    = 6'd34;
   localparam kind_type TK_TRUE    = 6'd35;
   localparam kind_type TK_VAR     = 6'd36;
   localparam kind_type TK_WHILE   = 6'd37;
   localparam kind_type TK_ERROR   = 6'd38;
   localparam kind_type TK_END     = 6'd39;

   localparam err_type ERR_NONE       = 2'd0;
   localparam err_type ERR_UNEXPECTED = 2'd1;
   localparam err_type ERR_UNTERM_STR = 2'd2;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // text holds the first six word bytes, first byte in the top bits
   function automatic kind_type keyword_kind(input logic [47:0] text,
                                             input logic [3:0]  len);
      kind_type k;
      k = TK_IDENT;
      if (len == 4'd2) begin
         if (text[47:32] == "if") k = TK_IF;
         if (text[47:32] == "or") k = TK_OR;
      end else if (len == 4'd3) begin
         if (text[47:24] == "and") k = TK_AND;
         if (text[47:24] == "for") k = TK_FOR;
         if (text[47:24] == "fun") k = TK_FUN;
         if (text[47:24] == "nil") k = TK_NIL;
         if (text[47:24] == "var") k = TK_VAR;
      end else if (len == 4'd4) begin
         if (text[47:16] == "else") k = TK_ELSE;
         if (text[47:16] == "this") k = TK_THIS;
         if (text[47:16] == "true") k = TK_TRUE;
      end else if (len == 4'd5) begin
         if (text[47:8] == "class") k = TK_CLASS;
         if (text[47:8] == "false") k = TK_FALSE;
         if (text[47:8] == "print") k = TK_PRINT;
         if (text[47:8] == "super") k = TK_SUPER;
         if (text[47:8] == "while") k = TK_WHILE;
      end else if (len == 4'd6) begin
         if (text == "return") k = TK_RETURN;
      end
      return k;
   endfunction

endpackage

>>> rtl/core/sltu_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sltu channel interfaces
// source byte channel and token channel, valid/ready handshake
// -----------------------------------------------------------------------------
interface sltu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_marker;

   modport source (output valid, source_byte, end_marker, input ready);
   modport sink   (input valid, source_byte, end_marker, output ready);
endinterface

interface sltu_rsp_if #(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 20
);
   logic                   valid;
   logic                   ready;
   logic [5:0]             token_kind;
   logic [1:0]             error_kind;
   logic [OFFSET_BITS-1:0] start_offset;
   logic [OFFSET_BITS-1:0] token_length;
   logic [LINE_BITS-1:0]   line_number;
   logic                   last_of_run;

   modport source (output valid, token_kind, error_kind, start_offset, token_length,
                   line_number, last_of_run, input ready);
   modport sink   (input valid, token_kind, error_kind, start_offset, token_length,
                   line_number, last_of_run, output ready);
endinterface

>>> rtl/core/sltu_scan.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sltu_scan
// scan state registers and single pass token logic, up to three tokens a word
// -----------------------------------------------------------------------------
module sltu_scan
   import sltu_pkg::*;
#(
   parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
   parameter int LINE_BITS       = LINE_BITS_DEF,
   parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
   parameter int ENTRY_BITS      = KIND_BITS + ERR_BITS + 2*OFFSET_BITS + LINE_BITS + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            source_byte,
   input  logic                  end_marker,
   output logic [1:0]            tok_count,
   output logic [ENTRY_BITS-1:0] tok_data [3]
);

   localparam int LEN_BITS = $clog2(KEYWORD_MAX_LEN + 2);
   localparam int IDX_BITS = $clog2(KEYWORD_MAX_LEN);
   localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [LEN_BITS-1:0]    KW_MAX   = LEN_BITS'(KEYWORD_MAX_LEN);

   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_IDENT   = 4'd1;
   localparam logic [3:0] M_INT     = 4'd2;
   localparam logic [3:0] M_DOT     = 4'd3;
   localparam logic [3:0] M_FRAC    = 4'd4;
   localparam logic [3:0] M_STR     = 4'd5;
   localparam logic [3:0] M_SLASH   = 4'd6;
   localparam logic [3:0] M_LINEC   = 4'd7;
   localparam logic [3:0] M_BLOCK   = 4'd8;
   localparam logic [3:0] M_BSTAR   = 4'd9;
   localparam logic [3:0] M_BANG    = 4'd10;
   localparam logic [3:0] M_EQUAL   = 4'd11;
   localparam logic [3:0] M_GREATER = 4'd12;
   localparam logic [3:0] M_LESS    = 4'd13;

   logic [3:0]             mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LEN_BITS-1:0]    wlen_ff, wlen_in;
   logic [7:0]             prefix_ff [KEYWORD_MAX_LEN];
   logic                   prefix_we;
   logic [IDX_BITS-1:0]    prefix_idx;

   logic [OFFSET_BITS-1:0] pos_next, pos_prev, span_p, span_dp, span_p1;
   logic [LINE_BITS-1:0]   line_next;
   logic [7:0]             c;
   logic                   do_flush, do_idle;
   kind_type               op_base, word_kind;

   logic a_v, b_v, c_v;
   kind_type a_kind, c_kind;
   err_type a_err, c_err;
   logic [OFFSET_BITS-1:0] a_start, a_len, c_start, c_len;
   logic [ENTRY_BITS-1:0]  ent_a, ent_b, ent_c;
   logic [1:0]             total;

   assign c         = source_byte;
   assign pos_next  = (pos_ff != OFF_MAX) ? pos_ff + 1'b1 : pos_ff;
   assign pos_prev  = (pos_ff != '0) ? pos_ff - 1'b1 : pos_ff;
   assign line_next = (line_ff != LINE_MAX) ? line_ff + 1'b1 : line_ff;
   assign span_p    = (pos_ff >= start_ff) ? pos_ff - start_ff : '0;
   assign span_dp   = (pos_prev >= start_ff) ? pos_prev - start_ff : '0;
   assign span_p1   = (pos_next >= start_ff) ? pos_next - start_ff : '0;
   assign word_kind = keyword_kind({prefix_ff[0], prefix_ff[1], prefix_ff[2],
                                    prefix_ff[3], prefix_ff[4], prefix_ff[5]},
                                   4'(wlen_ff));

   always_comb begin
      unique case (mode_ff)
         M_BANG:    op_base = TK_BANG;
         M_EQUAL:   op_base = TK_EQUAL;
         M_GREATER: op_base = TK_GREATER;
         default:   op_base = TK_LESS;
      endcase
   end

   // pending token flushed when the current lexeme ends
   always_comb begin
      a_v = 1'b1; b_v = 1'b0;
      a_kind = TK_NUMBER; a_err = ERR_NONE; a_start = start_ff; a_len = span_p;
      unique case (mode_ff)
         M_IDENT: a_kind = word_kind;
         M_INT, M_FRAC: a_kind = TK_NUMBER;
         M_DOT: begin
            a_len = span_dp;
            b_v   = 1'b1;
         end
         M_STR: begin
            a_kind = TK_ERROR; a_err = ERR_UNTERM_STR; a_len = '0;
         end
         M_SLASH: begin
            a_kind = TK_SLASH; a_len = OFFSET_BITS'(1);
         end
         M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
            a_kind = op_base; a_len = OFFSET_BITS'(1);
         end
         default: a_v = 1'b0;
      endcase
      a_v = a_v & do_flush;
      b_v = b_v & do_flush;
   end

   always_comb begin
      mode_in = mode_ff; start_in = start_ff; pos_in = pos_ff;
      line_in = line_ff; wlen_in = wlen_ff;
      prefix_we = 1'b0; prefix_idx = '0;
      do_flush = 1'b0; do_idle = 1'b0;
      c_v = 1'b0; c_kind = TK_END; c_err = ERR_NONE; c_start = pos_ff; c_len = '0;
      if (accept) begin
         if (end_marker) begin
            do_flush = 1'b1;
            c_v = 1'b1;
            mode_in = M_IDLE; start_in = '0; pos_in = '0;
            line_in = LINE_BITS'(1); wlen_in = '0;
         end else begin
            pos_in = pos_next;
            unique case (mode_ff)
               M_IDENT: begin
                  if (is_alpha(c) || is_digit(c)) begin
                     if (wlen_ff < KW_MAX) begin
                        prefix_we  = 1'b1;
                        prefix_idx = wlen_ff[IDX_BITS-1:0];
                     end
                     if (wlen_ff <= KW_MAX) wlen_in = wlen_ff + 1'b1;
                  end else begin
                     do_flush = 1'b1; do_idle = 1'b1;
                  end
               end
               M_INT: begin
                  if (c == ".") mode_in = M_DOT;
                  else if (!is_digit(c)) begin
                     do_flush = 1'b1; do_idle = 1'b1;
                  end
               end
               M_DOT: begin
                  if (is_digit(c)) mode_in = M_FRAC;
                  else begin
                     do_flush = 1'b1; do_idle = 1'b1;
                  end
               end
               M_FRAC: begin
                  if (!is_digit(c)) begin
                     do_flush = 1'b1; do_idle = 1'b1;
                  end
               end
               M_STR: begin
                  if (c == "\"") begin
                     c_v = 1'b1; c_kind = TK_STRING; c_start = start_ff; c_len = span_p1;
                     mode_in = M_IDLE;
                  end else if (c == "\n") begin
                     line_in = line_next;
                  end
               end
               M_SLASH: begin
                  if (c == "/") mode_in = M_LINEC;
                  else if (c == "*") mode_in = M_BLOCK;
                  else begin
                     do_flush = 1'b1; do_idle = 1'b1;
                  end
               end
               M_LINEC: begin
                  if (c == "\n") begin
                     line_in = line_next; mode_in = M_IDLE;
                  end
               end
               M_BLOCK, M_BSTAR: begin
                  if (c == "/" && mode_ff == M_BSTAR) mode_in = M_IDLE;
                  else if (c == "*") mode_in = M_BSTAR;
                  else begin
                     if (c == "\n") line_in = line_next;
                     mode_in = M_BLOCK;
                  end
               end
               M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
                  if (c == "=") begin
                     c_v = 1'b1; c_kind = op_base + 1'b1; c_start = start_ff;
                     c_len = span_p1; mode_in = M_IDLE;
                  end else begin
                     do_flush = 1'b1; do_idle = 1'b1;
                  end
               end
               default: do_idle = 1'b1;
            endcase
            if (do_idle) begin
               mode_in  = M_IDLE;
               start_in = pos_ff;
               c_start  = pos_ff;
               c_len    = pos_next - pos_ff;
               c_v      = 1'b1;
               c_kind   = TK_ERROR;
               case (c)
                  " ", 8'h0d, "\t": c_v = 1'b0;
                  "\n": begin
                     c_v = 1'b0; line_in = line_next;
                  end
                  "(": c_kind = TK_LPAREN;
                  ")": c_kind = TK_RPAREN;
                  "{": c_kind = TK_LBRACE;
                  "}": c_kind = TK_RBRACE;
                  ",": c_kind = TK_COMMA;
                  ".": c_kind = TK_DOT;
                  "-": c_kind = TK_MINUS;
                  "+": c_kind = TK_PLUS;
                  ";": c_kind = TK_SEMI;
                  "*": c_kind = TK_STAR;
                  "/": begin c_v = 1'b0; mode_in = M_SLASH;   end
                  "!": begin c_v = 1'b0; mode_in = M_BANG;    end
                  "=": begin c_v = 1'b0; mode_in = M_EQUAL;   end
                  ">": begin c_v = 1'b0; mode_in = M_GREATER; end
                  "<": begin c_v = 1'b0; mode_in = M_LESS;    end
                  "\"": begin c_v = 1'b0; mode_in = M_STR;    end
                  default: begin
                     if (is_alpha(c)) begin
                        c_v = 1'b0; mode_in = M_IDENT; wlen_in = LEN_BITS'(1);
                        prefix_we = 1'b1; prefix_idx = '0;
                     end else if (is_digit(c)) begin
                        c_v = 1'b0; mode_in = M_INT;
                     end else begin
                        c_err = ERR_UNEXPECTED; c_len = '0;
                     end
                  end
               endcase
            end
         end
      end
   end

   // compact the three slots, mark the final token of the word
   assign total = 2'(a_v) + 2'(b_v) + 2'(c_v);
   assign ent_a = {a_kind, a_err, a_start, a_len, line_ff, 1'b0};
   assign ent_b = {TK_DOT, ERR_NONE, pos_prev, OFFSET_BITS'(1), line_ff, 1'b0};
   assign ent_c = {c_kind, c_err, c_start, c_len, line_ff, 1'b0};

   always_comb begin
      tok_data[0] = a_v ? ent_a : ent_c;
      tok_data[1] = b_v ? ent_b : ent_c;
      tok_data[2] = ent_c;
      tok_data[0][0] = (total == 2'd1);
      tok_data[1][0] = (total == 2'd2);
      tok_data[2][0] = 1'b1;
   end
   assign tok_count = total;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
         line_ff  <= LINE_BITS'(1);
         wlen_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         wlen_ff  <= wlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prefix_we) prefix_ff[prefix_idx] <= c;
   end

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0) else $error("line count reached zero");
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      accept && end_marker |-> total != 2'd0) else $error("end word without end token");
   a_dot_pair: assert property (@(posedge clock) disable iff (reset)
      b_v |-> a_v && mode_ff == M_DOT) else $error("dot token without number");
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      accept && !end_marker && $past(reset) == 1'b0 |=> pos_ff != '0)
      else $error("byte position wrapped");

endmodule

>>> rtl/core/sltu_queue.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sltu_queue
// four entry token queue, takes up to three tokens a cycle, gives one while out_ready is high
// -----------------------------------------------------------------------------
module sltu_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  logic [WIDTH-1:0] push_data [3],
   output logic             has_room,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int DEPTH = 4;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]       count_ff, count_in;
   logic             pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = count_ff != 3'd0;
   assign out_data  = mem_ff[rd_ff];
   assign has_room  = count_ff <= 3'd1;
   assign wr_in     = wr_ff + push_count;
   assign rd_in     = rd_ff + 2'(pop);
   assign count_in  = count_ff + 3'(push_count) - 3'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count > 2'd0) mem_ff[wr_ff]        <= push_data[0];
      if (push_count > 2'd1) mem_ff[wr_ff + 2'd1] <= push_data[1];
      if (push_count > 2'd2) mem_ff[wr_ff + 2'd2] <= push_data[2];
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(DEPTH)) else $error("queue count overflow");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> count_ff + 3'(push_count) <= 3'(DEPTH))
      else $error("queue overrun");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      2'(wr_ff - rd_ff) == count_ff[1:0]) else $error("queue pointers disagree");

endmodule

>>> rtl/core/script_language_tokenizer_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// script_language_tokenizer_unit
// streaming lexical scanner: source bytes in, completed tokens out
//
//   channel   dir   carries
//   req_if    in    source_byte, end_marker
//   rsp_if    out   token_kind, error_kind, start_offset, token_length,
//                   line_number, last_of_run
//
// one source word a cycle; each word is scanned combinationally and yields
// zero to three tokens into a four entry queue, drained one token a cycle
// a word is taken while the queue holds at most one token
// synchronous reset returns to line one, offset zero, between tokens
// a stalled token output holds off input once two tokens wait in the queue
// -----------------------------------------------------------------------------
module script_language_tokenizer_unit
   import sltu_pkg::*;
#(
   parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
   parameter int LINE_BITS       = LINE_BITS_DEF,
   parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
) (
   input logic         clock,
   input logic         reset,
   sltu_req_if.sink    req_if,
   sltu_rsp_if.source  rsp_if
);

   localparam int ENTRY_BITS = KIND_BITS + ERR_BITS + 2*OFFSET_BITS + LINE_BITS + 1;

   logic                  accept, has_room;
   logic [1:0]            tok_count;
   logic [ENTRY_BITS-1:0] tok_data [3];
   logic [ENTRY_BITS-1:0] head;

   assign req_if.ready = has_room;
   assign accept       = req_if.valid && has_room;

   sltu_scan #(
      .OFFSET_BITS     (OFFSET_BITS),
      .LINE_BITS       (LINE_BITS),
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
      .ENTRY_BITS      (ENTRY_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_byte (req_if.source_byte),
      .end_marker  (req_if.end_marker),
      .tok_count   (tok_count),
      .tok_data    (tok_data)
   );

   sltu_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (tok_count),
      .push_data  (tok_data),
      .has_room   (has_room),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_data   (head)
   );

   assign {rsp_if.token_kind, rsp_if.error_kind, rsp_if.start_offset,
           rsp_if.token_length, rsp_if.line_number, rsp_if.last_of_run} = head;

endmodule
